FILE: src/mlpf_pkg.sv
// shared constants, types and the sigmoid table for the mlp forward pass unit
package mlpf_pkg;

	localparam int unsigned WEIGHT_DEPTH_DEF = 32768;
	localparam int unsigned BIAS_DEPTH_DEF = 4096;
	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned MAX_OUT_DEF = 64;
	localparam int unsigned MAX_LAYERS_DEF = 4;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned ADDR_W = 15;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned ACC_W = 40;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned NL_W = 3;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned OSIZE_W = 7;
	localparam int unsigned SIG_N = 1024;
	localparam logic [63:0] EXP_STEP = 64'd2114190000;

	localparam logic [NL_W-1:0] NUM_LAYERS_RST = 3'd3;
	localparam logic [SIZE_W-1:0] SIZE_IN_RST = 11'd784;
	localparam logic [SIZE_W-1:0] SIZE_HID_RST = 11'd30;
	localparam logic [OSIZE_W-1:0] SIZE_OUT_RST = 7'd10;

	typedef enum logic [REQ_W-1:0] {
		REQ_WEIGHT = 2'd0,
		REQ_BIAS   = 2'd1,
		REQ_INPUT  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_LAYERS = 3'd0,
		CFG_SIZE_IN    = 3'd1,
		CFG_SIZE_H1    = 3'd2,
		CFG_SIZE_H2    = 3'd3,
		CFG_SIZE_OUT   = 3'd4,
		CFG_ACT_MODE   = 3'd5
	} cfg_idx_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic rd_valid;
		logic w_zero;
		logic bias_add;
		logic b_zero;
		logic relu;
	} mac_ctrl_t;

	typedef logic [DATA_W-1:0] sig_tab_t [SIG_N];

	function automatic sig_tab_t build_sig();
		sig_tab_t t;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		logic [63:0] q;
		logic [63:0] rem;
		int m;
		int b;
		e = 64'd1 << 31;
		for (m = 0; m <= 512; m++) begin
			d = (64'd1 << 31) + e;
			num = (64'd1 << 43) + (d >> 1);
			q = '0;
			rem = '0;
			// restoring long division
			for (b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= d) begin
					rem = rem - d;
					q[b] = 1'b1;
				end
			end
			if (m < 512)
				t[512 + m] = q[DATA_W-1:0];
			if (m >= 1)
				t[512 - m] = 16'd4096 - q[DATA_W-1:0];
			e = (e * EXP_STEP + (64'd1 << 30)) >> 31;
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig();

endpackage

FILE: src/mlpf_if.sv
// handshake channels of the mlp forward pass unit
interface mlpf_in_if;
	logic valid;
	logic ready;
	logic [mlpf_pkg::REQ_W-1:0] req_type;
	logic [mlpf_pkg::ADDR_W-1:0] mem_address;
	logic signed [mlpf_pkg::DATA_W-1:0] data_value;
	modport source (output valid, output req_type, output mem_address, output data_value,
		input ready);
	modport sink (input valid, input req_type, input mem_address, input data_value,
		output ready);
endinterface

interface mlpf_out_if;
	logic valid;
	logic ready;
	logic signed [mlpf_pkg::DATA_W-1:0] result_value;
	logic [mlpf_pkg::IDX_W-1:0] result_index;
	logic last_result;
	modport source (output valid, output result_value, output result_index,
		output last_result, input ready);
	modport sink (input valid, input result_value, input result_index,
		input last_result, output ready);
endinterface

interface mlpf_cfg_if;
	logic valid;
	logic ready;
	logic [mlpf_pkg::CFG_IDX_W-1:0] reg_index;
	logic [mlpf_pkg::CFG_DATA_W-1:0] wr_data;
	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: src/mlpf_ram.sv
// generic single-write, single-read ram with registered read data
module mlpf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end
endmodule

FILE: src/mlpf_mac.sv
// shared multiply-accumulate unit with rounding, saturation and activation
module mlpf_mac (
	input  logic clk,
	input  logic arst_n,
	input  mlpf_pkg::mac_ctrl_t ctrl,
	input  logic [mlpf_pkg::DATA_W-1:0] w_data,
	input  logic [mlpf_pkg::DATA_W-1:0] a_data,
	input  logic [mlpf_pkg::DATA_W-1:0] b_data,
	output logic busy,
	output logic [mlpf_pkg::DATA_W-1:0] act_out
);
	logic signed [2*mlpf_pkg::DATA_W-1:0] prod_s2;
	logic mul_v_s2;
	logic [mlpf_pkg::ACC_W-1:0] acc_q;
	logic signed [mlpf_pkg::DATA_W-1:0] w_eff;
	logic signed [mlpf_pkg::DATA_W-1:0] b_eff;
	logic signed [mlpf_pkg::ACC_W:0] rnd;
	logic signed [mlpf_pkg::ACC_W-12:0] q;
	logic signed [mlpf_pkg::DATA_W-1:0] sat;
	logic [9:0] sig_idx;

	assign w_eff = ctrl.w_zero ? '0 : $signed(w_data);
	assign b_eff = ctrl.b_zero ? '0 : $signed(b_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else begin
			mul_v_s2 <= ctrl.rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_eff * $signed(a_data);
		if (ctrl.clear)
			acc_q <= '0;
		else if (mul_v_s2)
			acc_q <= acc_q + mlpf_pkg::ACC_W'(prod_s2);
		else if (ctrl.bias_add)
			acc_q <= acc_q + {mlpf_pkg::ACC_W'(b_eff) << 12};
	end

	// round half up to q4.12, then clamp to 16 bits
	always_comb begin
		rnd = $signed({acc_q[mlpf_pkg::ACC_W-1], acc_q}) + 41'sd2048;
		q = rnd[mlpf_pkg::ACC_W:12];
		if (q > 29'sd32767)
			sat = 16'sh7fff;
		else if (q < -29'sd32768)
			sat = 16'sh8000;
		else
			sat = q[mlpf_pkg::DATA_W-1:0];
		sig_idx = {~sat[15], sat[14:6]};
		if (ctrl.relu)
			act_out = sat[15] ? '0 : sat;
		else
			act_out = mlpf_pkg::SIG_TAB[sig_idx];
	end

	assign busy = mul_v_s2;
endmodule

FILE: src/mlp_feedforward_inference_unit.sv
// top level: load port, layer sequencer, memories and result output
// a weight, bias or non-final input item is taken on each valid handshake; ready stays high between them
// the final input element starts a pass over all layers, row by row, computed
// by the one shared multiply-accumulate unit doing one weight product per cycle
// each output element then goes through read, load and wait states, waiting there for the result side
// reset clears control and sets configuration to its defaults; memory contents stay undefined until written
module mlp_feedforward_inference_unit #(
	parameter int unsigned WEIGHT_DEPTH = mlpf_pkg::WEIGHT_DEPTH_DEF,
	parameter int unsigned BIAS_DEPTH = mlpf_pkg::BIAS_DEPTH_DEF,
	parameter int unsigned MAX_WIDTH = mlpf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_OUT = mlpf_pkg::MAX_OUT_DEF,
	parameter int unsigned MAX_LAYERS = mlpf_pkg::MAX_LAYERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mlpf_in_if.sink in_ch,
	mlpf_out_if.source out_ch,
	mlpf_cfg_if.sink cfg_ch
);
	localparam int unsigned WA_W = $clog2(WEIGHT_DEPTH);
	localparam int unsigned BA_W = $clog2(BIAS_DEPTH);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned SZ_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WC_W = $clog2(3 * MAX_WIDTH * MAX_WIDTH + 1);
	localparam int unsigned BC_W = $clog2(3 * MAX_WIDTH + 1);
	localparam int unsigned OUT_MAX = MAX_OUT < MAX_WIDTH ? MAX_OUT : MAX_WIDTH;
	localparam int unsigned LMAX = MAX_LAYERS < 4 ? MAX_LAYERS : 4;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MAC   = 8'b0000_0010,
		S_DRAIN = 8'b0000_0100,
		S_BIAS  = 8'b0000_1000,
		S_WB    = 8'b0001_0000,
		S_ORD   = 8'b0010_0000,
		S_OLD   = 8'b0100_0000,
		S_OWAIT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [mlpf_pkg::NL_W-1:0] num_layers_q;
	logic [mlpf_pkg::SIZE_W-1:0] size_in_q;
	logic [mlpf_pkg::SIZE_W-1:0] size_h1_q;
	logic [mlpf_pkg::SIZE_W-1:0] size_h2_q;
	logic [mlpf_pkg::OSIZE_W-1:0] size_out_q;
	logic act_mode_q;

	logic [mlpf_pkg::NL_W-1:0] nl;
	logic [SZ_W-1:0] lsz [4];
	logic [SZ_W-1:0] rows;
	logic [SZ_W-1:0] cols;
	logic [mlpf_pkg::NL_W-1:0] lyr_q;
	logic [AW-1:0] row_q;
	logic [AW-1:0] col_q;
	logic [AW-1:0] orow_q;
	logic [WC_W-1:0] wcnt_q;
	logic [BC_W-1:0] bcnt_q;
	logic rd_v_s1;
	logic woob_s1;
	logic boob_q;
	logic out_odd_q;
	logic out_v_q;
	logic [mlpf_pkg::DATA_W-1:0] res_val_q;
	logic [mlpf_pkg::IDX_W-1:0] res_idx_q;
	logic res_last_q;

	logic [31:0] in_addr32;
	logic in_acc;
	logic issue;
	logic src_even;
	logic [31:0] orow32;
	logic row_last;
	logic orow_last;

	logic w_we;
	logic b_we;
	logic e_we;
	logic o_we;
	logic e_re;
	logic o_re;
	logic [AW-1:0] e_waddr;
	logic [AW-1:0] o_waddr;
	logic [AW-1:0] a_raddr;
	logic [mlpf_pkg::DATA_W-1:0] e_wdata;
	logic [mlpf_pkg::DATA_W-1:0] w_rdata;
	logic [mlpf_pkg::DATA_W-1:0] b_rdata;
	logic [mlpf_pkg::DATA_W-1:0] e_rdata;
	logic [mlpf_pkg::DATA_W-1:0] o_rdata;
	logic [mlpf_pkg::DATA_W-1:0] act_out;
	logic mac_busy;
	mlpf_pkg::mac_ctrl_t mac_ctrl;

	function automatic logic [SZ_W-1:0] clip_size(logic [mlpf_pkg::SIZE_W-1:0] v,
		int unsigned lim);
		logic [31:0] r;
		r = 32'(v);
		if (r == 0)
			r = 1;
		else if (r > lim)
			r = lim;
		return r[SZ_W-1:0];
	endfunction

	always_comb begin
		if (num_layers_q < 3'd2)
			nl = 3'd2;
		else if (32'(num_layers_q) > LMAX)
			nl = mlpf_pkg::NL_W'(LMAX);
		else
			nl = num_layers_q;
		lsz[0] = clip_size(size_in_q, MAX_WIDTH);
		lsz[1] = clip_size(size_h1_q, MAX_WIDTH);
		lsz[2] = clip_size(size_h2_q, MAX_WIDTH);
		lsz[3] = '0;
		lsz[nl[1:0] - 2'd1] = clip_size(mlpf_pkg::SIZE_W'(size_out_q), OUT_MAX);
		rows = lsz[lyr_q[1:0]];
		cols = lsz[lyr_q[1:0] - 2'd1];
	end

	assign in_addr32 = 32'(in_ch.mem_address);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign issue = state_q == S_MAC;
	// layer one reads the input held in the even buffer
	assign src_even = lyr_q[0];
	assign orow32 = 32'(orow_q);
	assign row_last = SZ_W'(row_q) == rows - 1'b1;
	assign orow_last = SZ_W'(orow_q) == lsz[nl[1:0] - 2'd1] - 1'b1;

	// configuration
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_layers_q <= mlpf_pkg::NUM_LAYERS_RST;
			size_in_q <= mlpf_pkg::SIZE_IN_RST;
			size_h1_q <= mlpf_pkg::SIZE_HID_RST;
			size_h2_q <= mlpf_pkg::SIZE_HID_RST;
			size_out_q <= mlpf_pkg::SIZE_OUT_RST;
			act_mode_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.reg_index)
				mlpf_pkg::CFG_NUM_LAYERS: num_layers_q <= cfg_ch.wr_data[mlpf_pkg::NL_W-1:0];
				mlpf_pkg::CFG_SIZE_IN: size_in_q <= cfg_ch.wr_data;
				mlpf_pkg::CFG_SIZE_H1: size_h1_q <= cfg_ch.wr_data;
				mlpf_pkg::CFG_SIZE_H2: size_h2_q <= cfg_ch.wr_data;
				mlpf_pkg::CFG_SIZE_OUT: size_out_q <= cfg_ch.wr_data[mlpf_pkg::OSIZE_W-1:0];
				mlpf_pkg::CFG_ACT_MODE: act_mode_q <= cfg_ch.wr_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lyr_q <= '0;
			row_q <= '0;
			col_q <= '0;
			orow_q <= '0;
			wcnt_q <= '0;
			bcnt_q <= '0;
			rd_v_s1 <= 1'b0;
			out_odd_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.req_type == mlpf_pkg::REQ_INPUT &&
						in_addr32 < MAX_WIDTH &&
						in_addr32 == 32'(lsz[0]) - 32'd1) begin
						state_q <= S_MAC;
						lyr_q <= 3'd1;
						row_q <= '0;
						col_q <= '0;
						wcnt_q <= '0;
						bcnt_q <= '0;
					end
				end
				S_MAC: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (SZ_W'(col_q) == cols - 1'b1) begin
						col_q <= '0;
						state_q <= S_DRAIN;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!rd_v_s1 && !mac_busy)
						state_q <= S_BIAS;
				end
				S_BIAS: state_q <= S_WB;
				S_WB: begin
					bcnt_q <= bcnt_q + 1'b1;
					if (row_last) begin
						row_q <= '0;
						if (lyr_q == nl - 1'b1) begin
							out_odd_q <= lyr_q[0];
							orow_q <= '0;
							state_q <= S_ORD;
						end else begin
							lyr_q <= lyr_q + 1'b1;
							state_q <= S_MAC;
						end
					end else begin
						row_q <= row_q + 1'b1;
						state_q <= S_MAC;
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					out_v_q <= 1'b1;
					state_q <= S_OWAIT;
				end
				S_OWAIT: begin
					if (out_ch.ready) begin
						out_v_q <= 1'b0;
						if (orow_last) begin
							state_q <= S_IDLE;
						end else begin
							orow_q <= orow_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		woob_s1 <= 32'(wcnt_q) >= WEIGHT_DEPTH;
		if (issue && col_q == '0)
			boob_q <= 32'(bcnt_q) >= BIAS_DEPTH;
		if (state_q == S_OLD) begin
			res_val_q <= out_odd_q ? o_rdata : e_rdata;
			res_idx_q <= orow32[mlpf_pkg::IDX_W-1:0];
			res_last_q <= orow_last;
		end
	end

	// memory ports
	assign w_we = in_acc && in_ch.req_type == mlpf_pkg::REQ_WEIGHT && in_addr32 < WEIGHT_DEPTH;
	assign b_we = in_acc && in_ch.req_type == mlpf_pkg::REQ_BIAS && in_addr32 < BIAS_DEPTH;
	assign e_we = (in_acc && in_ch.req_type == mlpf_pkg::REQ_INPUT && in_addr32 < MAX_WIDTH) ||
		(state_q == S_WB && !lyr_q[0]);
	assign o_we = state_q == S_WB && lyr_q[0];
	assign e_waddr = state_q == S_IDLE ? in_addr32[AW-1:0] : row_q;
	assign o_waddr = row_q;
	assign e_wdata = state_q == S_IDLE ? in_ch.data_value : act_out;
	assign a_raddr = issue ? col_q : orow_q;
	assign e_re = (issue && src_even) || (state_q == S_ORD && !out_odd_q);
	assign o_re = (issue && !src_even) || (state_q == S_ORD && out_odd_q);

	mlpf_ram #(.WIDTH(mlpf_pkg::DATA_W), .DEPTH(WEIGHT_DEPTH)) u_wmem (
		.clk(clk), .we(w_we), .waddr(in_addr32[WA_W-1:0]), .wdata(in_ch.data_value),
		.re(issue), .raddr(wcnt_q[WA_W-1:0]), .rdata_q(w_rdata)
	);

	mlpf_ram #(.WIDTH(mlpf_pkg::DATA_W), .DEPTH(BIAS_DEPTH)) u_bmem (
		.clk(clk), .we(b_we), .waddr(in_addr32[BA_W-1:0]), .wdata(in_ch.data_value),
		.re(issue && col_q == '0), .raddr(bcnt_q[BA_W-1:0]), .rdata_q(b_rdata)
	);

	mlpf_ram #(.WIDTH(mlpf_pkg::DATA_W), .DEPTH(MAX_WIDTH)) u_abuf_even (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(e_re), .raddr(a_raddr), .rdata_q(e_rdata)
	);

	mlpf_ram #(.WIDTH(mlpf_pkg::DATA_W), .DEPTH(MAX_WIDTH)) u_abuf_odd (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(act_out),
		.re(o_re), .raddr(a_raddr), .rdata_q(o_rdata)
	);

	always_comb begin
		mac_ctrl.clear = state_q == S_IDLE || state_q == S_WB;
		mac_ctrl.rd_valid = rd_v_s1;
		mac_ctrl.w_zero = woob_s1;
		mac_ctrl.bias_add = state_q == S_BIAS;
		mac_ctrl.b_zero = boob_q;
		mac_ctrl.relu = act_mode_q;
	end

	mlpf_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctrl(mac_ctrl),
		.w_data(w_rdata), .a_data(src_even ? e_rdata : o_rdata), .b_data(b_rdata),
		.busy(mac_busy), .act_out(act_out)
	);

	assign in_ch.ready = state_q == S_IDLE;
	assign out_ch.valid = out_v_q;
	assign out_ch.result_value = res_val_q;
	assign out_ch.result_index = res_idx_q;
	assign out_ch.last_result = res_last_q;

	a_no_out_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("result pending while taking items");
	a_wb_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |-> !mac_busy && !rd_v_s1) else $error("write back before drain");
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.last_result |=> in_ch.ready)
		else $error("not idle after last result");
	a_acc_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> !mac_busy) else $error("stale product after idle");
endmodule
